// ===== rtl/eci_pkg.sv =====
package eci_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int TIME_BITS_DEF = 16;

    // Curve mode codes
    typedef enum logic [3:0] {
        MODE_CIRC      = 4'd0,
        MODE_CIRC_IN   = 4'd1,
        MODE_CIRC_OUT  = 4'd2,
        MODE_LINEAR    = 4'd3,
        MODE_QUAD      = 4'd4,
        MODE_QUAD_IN   = 4'd5,
        MODE_QUAD_OUT  = 4'd6,
        MODE_CUBIC     = 4'd7,
        MODE_CUBIC_IN  = 4'd8,
        MODE_CUBIC_OUT = 4'd9
    } mode_t;

    // Register indexes
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_START = 2'd1;
    localparam logic [1:0] REG_CHG   = 2'd2;
    localparam logic [1:0] REG_DUR   = 2'd3;

endpackage

// ===== rtl/eci_divider.sv =====
// Pipelined restoring divider: quotient of (t << FB) / d, one bit a stage.
module eci_divider #(
    parameter int FB = 16,
    parameter int TB = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [TB-1:0] num,
    input  logic [TB-1:0] den,
    input  logic [3:0]    mode_in,
    input  logic          clamp_in,
    output logic          out_valid,
    output logic [FB:0]   quot,
    output logic [3:0]    mode_out,
    output logic          clamp_out
);
    import eci_pkg::*;

    // t <= d, so the quotient fits in FB+1 bits: one stage per quotient bit
    localparam int NS = FB + 1;

    logic          vld_reg  [NS+1];
    logic [TB:0]   rem_reg  [NS+1];
    logic [FB:0]   q_reg    [NS+1];
    logic [TB-1:0] d_reg    [NS+1];
    logic [3:0]    m_reg    [NS+1];
    logic          c_reg    [NS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i <= NS; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Entry: remainder holds t, quotient cleared
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= {1'b0, num};
        q_reg[0]   <= '0;
        d_reg[0]   <= den;
        m_reg[0]   <= mode_in;
        c_reg[0]   <= clamp_in;
    end

    // Stage i yields quotient bit FB-i+1 .. first stage gives the integer bit
    for (genvar s = 1; s <= NS; s++)
    begin : g_stage
        logic [TB+1:0] trial;
        logic          ge;
        logic [TB:0]   rem_next;
        always_comb
        begin
            if (s == 1)
            begin
                trial = {1'b0, rem_reg[s-1]};
            end
            else
            begin
                trial = {rem_reg[s-1], 1'b0};
            end
            ge = trial >= {2'b00, d_reg[s-1]};
            rem_next = ge ? (TB+1)'(trial - {2'b00, d_reg[s-1]}) : trial[TB:0];
        end
        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next;
            q_reg[s]   <= {q_reg[s-1][FB-1:0], ge};
            d_reg[s]   <= d_reg[s-1];
            m_reg[s]   <= m_reg[s-1];
            c_reg[s]   <= c_reg[s-1];
        end
    end

    assign out_valid = vld_reg[NS];
    assign quot      = q_reg[NS];
    assign mode_out  = m_reg[NS];
    assign clamp_out = c_reg[NS];

endmodule

// ===== rtl/eci_sqrt.sv =====
// Pipelined integer square root of a 2*(FB+1) bit value, one result bit a stage.
module eci_sqrt #(
    parameter int FB = 16,
    parameter int SB = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [2*FB+1:0] rad,
    input  logic [SB-1:0]   side_in,
    input  logic            in_valid,
    output logic [FB:0]     root,
    output logic [SB-1:0]   side_out,
    output logic            out_valid
);
    import eci_pkg::*;

    localparam int NS = FB + 1;
    localparam int RW = 2 * FB + 2;

    logic          vld_reg [NS+1];
    logic [RW-1:0] x_reg   [NS+1];
    logic [FB:0]   r_reg   [NS+1];
    logic [RW+1:0] rem_reg [NS+1];
    logic [SB-1:0] s_reg   [NS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i <= NS; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]   <= rad;
        r_reg[0]   <= '0;
        rem_reg[0] <= '0;
        s_reg[0]   <= side_in;
    end

    // Digit-by-digit: bring down two bits, trial subtract 4r+1
    for (genvar k = 1; k <= NS; k++)
    begin : g_stage
        logic [RW+1:0] cur;
        logic [RW+1:0] trial;
        logic          ge;
        always_comb
        begin
            cur   = {rem_reg[k-1][RW-1:0], x_reg[k-1][RW-1:RW-2]};
            trial = {{(RW-FB-1){1'b0}}, r_reg[k-1], 2'b01};
            ge    = cur >= trial;
        end
        always_ff @(posedge clk)
        begin
            rem_reg[k] <= ge ? (cur - trial) : cur;
            r_reg[k]   <= {r_reg[k-1][FB-1:0], ge};
            x_reg[k]   <= {x_reg[k-1][RW-3:0], 2'b00};
            s_reg[k]   <= s_reg[k-1];
        end
    end

    assign root      = r_reg[NS];
    assign side_out  = s_reg[NS];
    assign out_valid = vld_reg[NS];

endmodule

// ===== rtl/eci_curve.sv =====
// Ease factor from the time fraction: squares, cubes and circular roots.
module eci_curve #(
    parameter int FB = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [FB:0] u,
    input  logic [3:0]  mode_in,
    input  logic        clamp_in,
    output logic        out_valid,
    output logic [FB:0] factor,
    output logic        clamp_out
);
    import eci_pkg::*;

    localparam logic [FB:0] ONE  = (FB+1)'(1) << FB;
    localparam logic [FB:0] HALF = (FB+1)'(1) << (FB - 1);
    localparam int          PW   = 2 * FB + 2;

    // Stage A: pick the operand and square it
    logic [FB:0] v_c, w_c, x_c;
    logic        low_c;
    logic        va_reg, ca_reg, la_reg;
    logic [3:0]  ma_reg;
    logic [FB:0] xa_reg, ua_reg;
    logic [PW-1:0] sq_reg;

    always_comb
    begin
        v_c   = ONE - u;
        low_c = u < HALF;
        w_c   = low_c ? {u[FB-1:0], 1'b0} : {v_c[FB-1:0], 1'b0};
        case (mode_in)
            MODE_CIRC, MODE_QUAD, MODE_CUBIC: x_c = w_c;
            MODE_CIRC_IN, MODE_QUAD_IN, MODE_CUBIC_IN: x_c = u;
            MODE_CIRC_OUT, MODE_QUAD_OUT, MODE_CUBIC_OUT: x_c = v_c;
            default: x_c = u;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= PW'(x_c) * PW'(x_c);
        xa_reg <= x_c;
        ua_reg <= u;
        ma_reg <= mode_in;
        ca_reg <= clamp_in;
        la_reg <= low_c;
    end

    // Stage B: rounded square, cube product, root radicand
    logic [FB+1:0] qs_c;
    logic          vb_reg, cb_reg, lb_reg;
    logic [3:0]    mb_reg;
    logic [FB:0]   ub_reg;
    logic [PW-1:0] sqb_reg;
    logic [PW-1:0] cube_reg;
    logic [PW-1:0] rad_reg;

    assign qs_c = (FB+2)'((sq_reg + PW'(HALF)) >> FB);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else
        begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sqb_reg  <= sq_reg;
        cube_reg <= PW'(qs_c[FB:0]) * PW'(xa_reg);
        rad_reg  <= PW'(PW'(ONE) * PW'(ONE) - sq_reg);
        ub_reg   <= ua_reg;
        mb_reg   <= ma_reg;
        cb_reg   <= ca_reg;
        lb_reg   <= la_reg;
    end

    // Stage C: non-circular factor; circular root runs alongside
    logic [FB:0] poly_c;
    logic [FB:0] qsq_c, qcu_c, gq_c, gc_c;
    always_comb
    begin
        qsq_c = (FB+1)'((sqb_reg + PW'(HALF)) >> FB);
        qcu_c = (FB+1)'((cube_reg + PW'(HALF)) >> FB);
        gq_c  = (FB+1)'((sqb_reg + PW'(ONE)) >> (FB + 1));
        gc_c  = (FB+1)'((cube_reg + PW'(ONE)) >> (FB + 1));
        case (mb_reg)
            MODE_QUAD:      poly_c = lb_reg ? gq_c : ONE - gq_c;
            MODE_QUAD_IN:   poly_c = qsq_c;
            MODE_QUAD_OUT:  poly_c = ONE - qsq_c;
            MODE_CUBIC:     poly_c = lb_reg ? gc_c : ONE - gc_c;
            MODE_CUBIC_IN:  poly_c = qcu_c;
            MODE_CUBIC_OUT: poly_c = ONE - qcu_c;
            default:        poly_c = ub_reg;
        endcase
    end

    // Side data carried through the root pipe: poly factor, mode, clamp, lower
    localparam int SBW = FB + 1 + 4 + 2;
    logic [SBW-1:0] side_o;
    logic [FB:0]    root_o;
    logic           rv_o;

    eci_sqrt #(.FB(FB), .SB(SBW)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .rad      (rad_reg),
        .side_in  ({poly_c, mb_reg, cb_reg, lb_reg}),
        .in_valid (vb_reg),
        .root     (root_o),
        .side_out (side_o),
        .out_valid(rv_o)
    );

    logic [FB:0] pf_o;
    logic [3:0]  m_o;
    logic        l_o;
    logic [FB+1:0] sum_lo, sum_hi;
    logic [FB:0] f_c;
    logic        fv_reg, fc_reg;
    logic [FB:0] f_reg;

    always_comb
    begin
        pf_o   = side_o[SBW-1:6];
        m_o    = side_o[5:2];
        l_o    = side_o[0];
        sum_lo = (FB+2)'(ONE) - (FB+2)'(root_o);
        sum_hi = (FB+2)'(ONE) + (FB+2)'(root_o);
        case (m_o)
            MODE_CIRC:     f_c = l_o ? sum_lo[FB+1:1] : sum_hi[FB+1:1];
            MODE_CIRC_IN:  f_c = ONE - root_o;
            MODE_CIRC_OUT: f_c = root_o;
            default:       f_c = pf_o;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else
        begin
            fv_reg <= rv_o;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg  <= f_c;
        fc_reg <= side_o[1];
    end

    assign out_valid = fv_reg;
    assign factor    = f_reg;
    assign clamp_out = fc_reg;

endmodule

// ===== rtl/easing_curve_interpolator.sv =====
// Path from start to done: clamp register at the accepting edge, then the divider,
// curve and scale stages.
// Throughput: one transaction per cycle; every stage is a register slice.
// The receiver cannot stall: each result shows for one cycle with done high.
// Reset: asynchronous active low; registers return to linear, b=0, c=0, d=1.
module easing_curve_interpolator #(
    parameter int FRAC_BITS = eci_pkg::FRAC_BITS_DEF,
    parameter int TIME_BITS = eci_pkg::TIME_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [TIME_BITS-1:0] elapsed_ticks,
    output logic                 done,
    output logic signed [31:0]   eased_position,
    output logic                 time_clamped,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_wdata
);
    import eci_pkg::*;

    localparam int FB = FRAC_BITS;
    localparam int TB = TIME_BITS;

    // Configuration registers
    logic [3:0]        mode_reg;
    logic signed [31:0] b_reg, c_reg;
    logic [TB-1:0]     d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_LINEAR;
            b_reg    <= '0;
            c_reg    <= '0;
            d_reg    <= TB'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:  mode_reg <= cfg_wdata[3:0];
                REG_START: b_reg    <= cfg_wdata;
                REG_CHG:   c_reg    <= cfg_wdata;
                REG_DUR:   d_reg    <= cfg_wdata[TB-1:0];
                default:   ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage 0: clamp tick count to duration
    logic [TB-1:0] d_eff;
    logic          v0_reg, c0_reg;
    logic [TB-1:0] t0_reg, d0_reg;
    logic [3:0]    m0_reg;

    assign d_eff = (d_reg == '0) ? TB'(1) : d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        c0_reg <= elapsed_ticks > d_eff;
        t0_reg <= (elapsed_ticks > d_eff) ? d_eff : elapsed_ticks;
        d0_reg <= d_eff;
        m0_reg <= mode_reg;
    end

    logic        dv, dc;
    logic [FB:0] uq;
    logic [3:0]  dm;

    eci_divider #(.FB(FB), .TB(TB)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v0_reg),
        .num      (t0_reg),
        .den      (d0_reg),
        .mode_in  (m0_reg),
        .clamp_in (c0_reg),
        .out_valid(dv),
        .quot     (uq),
        .mode_out (dm),
        .clamp_out(dc)
    );

    logic        fv, fc;
    logic [FB:0] fq;

    eci_curve #(.FB(FB)) u_curve (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (dv),
        .u        (uq),
        .mode_in  (dm),
        .clamp_in (dc),
        .out_valid(fv),
        .factor   (fq),
        .clamp_out(fc)
    );

    // Scale: c*f, round, add b, saturate
    localparam int PW = 32 + FB + 2;
    logic              s1v_reg, s1c_reg, s2v_reg, s2c_reg, s3v_reg, s3c_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-FB:0] pos_reg;
    logic signed [31:0] out_reg;
    logic signed [PW-1:0] rnd_c;
    logic signed [PW-FB:0] sum_c;

    assign rnd_c = prod_reg + PW'(1 << (FB - 1));
    assign sum_c = (PW-FB+1)'(rnd_c >>> FB) + (PW-FB+1)'(b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1v_reg <= 1'b0;
            s2v_reg <= 1'b0;
            s3v_reg <= 1'b0;
        end
        else
        begin
            s1v_reg <= fv;
            s2v_reg <= s1v_reg;
            s3v_reg <= s2v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(c_reg) * $signed({1'b0, fq});
        s1c_reg  <= fc;
        pos_reg  <= sum_c;
        s2c_reg  <= s1c_reg;
        if (pos_reg > (PW-FB+1)'(32'sh7FFF_FFFF))
        begin
            out_reg <= 32'sh7FFF_FFFF;
        end
        else if (pos_reg < -(PW-FB+1)'(33'sh0_8000_0000))
        begin
            out_reg <= 32'sh8000_0000;
        end
        else
        begin
            out_reg <= pos_reg[31:0];
        end
        s3c_reg <= s2c_reg;
    end

    assign done           = s3v_reg;
    assign eased_position = out_reg;
    assign time_clamped   = s3c_reg;

endmodule
